// ===== src/obb_separating_axis_test_macros.svh =====
// Assertion macros for the oriented-rectangle overlap block.
// Included by the checker; needs a clock named i_clk and reset i_rst_n in scope.
`ifndef OBB_SEPARATING_AXIS_TEST_MACROS_SVH
`define OBB_SEPARATING_AXIS_TEST_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OBB_SAT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define OBB_SAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/obb_sat_pkg.sv =====
// Shared constants for the oriented-rectangle overlap block.
// No dependencies; used by the queue, front, back, top level, checker and testbench.
`timescale 1ns / 1ps

package obb_sat_pkg;

    // Coordinates of one rectangle, in storage order
    localparam int NUM_COORDS = 8;
    localparam int IDX_CX     = 0;
    localparam int IDX_CY     = 1;
    localparam int IDX_C0X    = 2;
    localparam int IDX_C0Y    = 3;
    localparam int IDX_C1X    = 4;
    localparam int IDX_C1Y    = 5;
    localparam int IDX_C2X    = 6;
    localparam int IDX_C2Y    = 7;

    // Request kinds
    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_TEST  = 1'b1;

    localparam int NUM_AXES = 4;
    localparam logic [2:0] AXIS_NONE = 3'd4;

    localparam int QUEUE_DEPTH = 2;

endpackage

// ===== src/obb_sat_fifo.sv =====
// Short request queue between the front and the back of the overlap block.
// Uses obb_sat_pkg for its default depth.
`timescale 1ns / 1ps

module obb_sat_fifo #(
    parameter int WIDTH = 256,
    parameter int DEPTH = obb_sat_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== src/obb_sat_front.sv =====
// Front of the overlap block: accepts items, keeps rectangle A, queues tests.
// Uses obb_sat_pkg for the coordinate order and the request kinds.
`timescale 1ns / 1ps

module obb_sat_front #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_kind,
    input  logic signed [COORD_WIDTH-1:0] i_center_x,
    input  logic signed [COORD_WIDTH-1:0] i_center_y,
    input  logic signed [COORD_WIDTH-1:0] i_corner0_x,
    input  logic signed [COORD_WIDTH-1:0] i_corner0_y,
    input  logic signed [COORD_WIDTH-1:0] i_corner1_x,
    input  logic signed [COORD_WIDTH-1:0] i_corner1_y,
    input  logic signed [COORD_WIDTH-1:0] i_corner2_x,
    input  logic signed [COORD_WIDTH-1:0] i_corner2_y,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output logic [2*obb_sat_pkg::NUM_COORDS-1:0][COORD_WIDTH-1:0] o_q_data
);

    localparam int   N          = obb_sat_pkg::NUM_COORDS;

    logic [N-1:0][COORD_WIDTH-1:0] r_rect_a;
    logic [N-1:0][COORD_WIDTH-1:0] rect_b;
    logic                          accept;

    always_comb begin
        rect_b[obb_sat_pkg::IDX_CX]  = i_center_x;
        rect_b[obb_sat_pkg::IDX_CY]  = i_center_y;
        rect_b[obb_sat_pkg::IDX_C0X] = i_corner0_x;
        rect_b[obb_sat_pkg::IDX_C0Y] = i_corner0_y;
        rect_b[obb_sat_pkg::IDX_C1X] = i_corner1_x;
        rect_b[obb_sat_pkg::IDX_C1Y] = i_corner1_y;
        rect_b[obb_sat_pkg::IDX_C2X] = i_corner2_x;
        rect_b[obb_sat_pkg::IDX_C2Y] = i_corner2_y;
    end

    // A store needs no queue slot, but stall stays simple: full queue stalls all
    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign o_q_push   = accept && (i_kind == obb_sat_pkg::KIND_TEST);
    assign o_q_data   = {r_rect_a, rect_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rect_a <= '0;
        end else if (accept && (i_kind == obb_sat_pkg::KIND_STORE)) begin
            r_rect_a <= rect_b;
        end
    end

endmodule

// ===== src/obb_sat_back.sv =====
// Back of the overlap block: projection pipeline (axes, products, absolute projections) and result register.
// Uses obb_sat_pkg for the coordinate order, axis count and the no-axis code.
`timescale 1ns / 1ps

module obb_sat_back #(
    parameter int COORD_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  logic [2*obb_sat_pkg::NUM_COORDS-1:0][COORD_WIDTH-1:0] i_q_data,
    output logic       o_q_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_overlap,
    output logic [2:0] o_separating_axis
);

    localparam int N    = obb_sat_pkg::NUM_COORDS;
    localparam int NA   = obb_sat_pkg::NUM_AXES;
    localparam int W    = COORD_WIDTH;
    localparam int DW   = W + 1;        // coordinate difference
    localparam int PW   = 2 * W + 2;    // one product
    localparam int AW   = 2 * W + 2;    // absolute dot product
    localparam int NV   = 5;            // vectors projected on every axis
    localparam int V_D  = 0;            // center difference
    localparam int V_A0 = 1;
    localparam int V_A1 = 2;
    localparam int V_B0 = 3;
    localparam int V_B1 = 4;

    function automatic logic signed [DW-1:0] diff(input logic [W-1:0] x, input logic [W-1:0] y);
        diff = $signed({x[W-1], x}) - $signed({y[W-1], y});
    endfunction

    // stage 1: axes and corner offsets
    logic                 r_v1;
    logic signed [DW-1:0] r_ax [NA];
    logic signed [DW-1:0] r_ay [NA];
    logic signed [DW-1:0] r_vx [NV];
    logic signed [DW-1:0] r_vy [NV];
    // stage 2: products
    logic                 r_v2;
    logic signed [PW-1:0] r_px [NA][NV];
    logic signed [PW-1:0] r_py [NA][NV];
    // stage 3: absolute projections
    logic                 r_v3;
    logic        [AW-1:0] r_proj [NA][NV];
    logic        [AW-1:0] n_proj [NA][NV];
    logic signed [PW:0]   dot;
    // output
    logic                 r_out_valid;
    logic                 r_overlap;
    logic [2:0]           r_axis;

    logic rdy1, rdy2, rdy3, rdy4;
    logic [N-1:0][W-1:0] a, b;

    logic [AW-1:0] rad_a, rad_b;
    logic [AW:0]   rsum;
    logic [NA-1:0] sep;
    logic [2:0]    found;

    assign rdy4 = !r_out_valid || !i_out_stall;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign o_q_pop = rdy1;

    assign a = i_q_data[2*N-1:N];
    assign b = i_q_data[N-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_q_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_out_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_ax[0] <= diff(a[obb_sat_pkg::IDX_C1X], a[obb_sat_pkg::IDX_C0X]);
            r_ay[0] <= diff(a[obb_sat_pkg::IDX_C1Y], a[obb_sat_pkg::IDX_C0Y]);
            r_ax[1] <= diff(a[obb_sat_pkg::IDX_C2X], a[obb_sat_pkg::IDX_C1X]);
            r_ay[1] <= diff(a[obb_sat_pkg::IDX_C2Y], a[obb_sat_pkg::IDX_C1Y]);
            r_ax[2] <= diff(b[obb_sat_pkg::IDX_C1X], b[obb_sat_pkg::IDX_C0X]);
            r_ay[2] <= diff(b[obb_sat_pkg::IDX_C1Y], b[obb_sat_pkg::IDX_C0Y]);
            r_ax[3] <= diff(b[obb_sat_pkg::IDX_C2X], b[obb_sat_pkg::IDX_C1X]);
            r_ay[3] <= diff(b[obb_sat_pkg::IDX_C2Y], b[obb_sat_pkg::IDX_C1Y]);
            r_vx[V_D]  <= diff(a[obb_sat_pkg::IDX_CX],  b[obb_sat_pkg::IDX_CX]);
            r_vy[V_D]  <= diff(a[obb_sat_pkg::IDX_CY],  b[obb_sat_pkg::IDX_CY]);
            r_vx[V_A0] <= diff(a[obb_sat_pkg::IDX_C0X], a[obb_sat_pkg::IDX_CX]);
            r_vy[V_A0] <= diff(a[obb_sat_pkg::IDX_C0Y], a[obb_sat_pkg::IDX_CY]);
            r_vx[V_A1] <= diff(a[obb_sat_pkg::IDX_C1X], a[obb_sat_pkg::IDX_CX]);
            r_vy[V_A1] <= diff(a[obb_sat_pkg::IDX_C1Y], a[obb_sat_pkg::IDX_CY]);
            r_vx[V_B0] <= diff(b[obb_sat_pkg::IDX_C0X], b[obb_sat_pkg::IDX_CX]);
            r_vy[V_B0] <= diff(b[obb_sat_pkg::IDX_C0Y], b[obb_sat_pkg::IDX_CY]);
            r_vx[V_B1] <= diff(b[obb_sat_pkg::IDX_C1X], b[obb_sat_pkg::IDX_CX]);
            r_vy[V_B1] <= diff(b[obb_sat_pkg::IDX_C1Y], b[obb_sat_pkg::IDX_CY]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            for (int i = 0; i < NA; i++) begin
                for (int v = 0; v < NV; v++) begin
                    r_px[i][v] <= PW'(r_ax[i] * r_vx[v]);
                    r_py[i][v] <= PW'(r_ay[i] * r_vy[v]);
                end
            end
        end
    end

    always_comb begin
        dot = '0;
        for (int i = 0; i < NA; i++) begin
            for (int v = 0; v < NV; v++) begin
                dot = $signed({r_px[i][v][PW-1], r_px[i][v]})
                    + $signed({r_py[i][v][PW-1], r_py[i][v]});
                n_proj[i][v] = dot[PW] ? AW'(-dot) : AW'(dot);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_proj <= n_proj;
        end
    end

    // compare each axis, take the first separating one in test order
    always_comb begin
        sep = '0;
        for (int i = 0; i < NA; i++) begin
            rad_a  = (r_proj[i][V_A1] > r_proj[i][V_A0]) ? r_proj[i][V_A1] : r_proj[i][V_A0];
            rad_b  = (r_proj[i][V_B1] > r_proj[i][V_B0]) ? r_proj[i][V_B1] : r_proj[i][V_B0];
            rsum   = {1'b0, rad_a} + {1'b0, rad_b};
            sep[i] = {1'b0, r_proj[i][V_D]} > rsum;
        end
        found = obb_sat_pkg::AXIS_NONE;
        for (int i = NA - 1; i >= 0; i--) begin
            if (sep[i]) found = 3'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_overlap <= (found == obb_sat_pkg::AXIS_NONE);
            r_axis    <= found;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_overlap         = r_overlap;
    assign o_separating_axis = r_axis;

endmodule

// ===== src/obb_separating_axis_test.sv =====
// Oriented-rectangle overlap test by separating axes: front, request queue, back.
// Uses obb_sat_pkg, obb_sat_front, obb_sat_fifo and obb_sat_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall): a request with i_kind 0 stores
//   rectangle A (center and three corners in order) and gives no result.
//   A request with i_kind 1 carries rectangle B and yields one result,
//   tested against the A stored at the time it is accepted.
//   Output channel (o_out_valid / i_out_stall): o_overlap is 1 when none of
//   the four axes separates; o_separating_axis gives the first separating
//   axis (A edge 0-1, A edge 1-2, B edge 0-1, B edge 1-2) or 4 for none.
//   Throughput: one request per cycle, stores and tests alike, while o_in_stall is low.
//   Path: a test is written into the two-entry request queue, then passes
//   through three stages (axes, products, absolute projections) before the
//   compare and priority logic that feeds the output register.
//   Reset (synchronous, active low) empties the queue and pipeline and sets
//   the stored rectangle A to all points at the origin.
//   While the receiver stalls, the result holds; the pipeline fills, then
//   the queue, and o_in_stall rises once the queue is full.
`timescale 1ns / 1ps

module obb_separating_axis_test #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_kind,
    input  logic signed [COORD_WIDTH-1:0] i_center_x,
    input  logic signed [COORD_WIDTH-1:0] i_center_y,
    input  logic signed [COORD_WIDTH-1:0] i_corner0_x,
    input  logic signed [COORD_WIDTH-1:0] i_corner0_y,
    input  logic signed [COORD_WIDTH-1:0] i_corner1_x,
    input  logic signed [COORD_WIDTH-1:0] i_corner1_y,
    input  logic signed [COORD_WIDTH-1:0] i_corner2_x,
    input  logic signed [COORD_WIDTH-1:0] i_corner2_y,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_overlap,
    output logic [2:0]                    o_separating_axis
);

    localparam int QW = 2 * obb_sat_pkg::NUM_COORDS * COORD_WIDTH;

    logic          q_full;
    logic          q_push;
    logic [QW-1:0] q_wdata;
    logic          q_valid;
    logic          q_pop;
    logic [QW-1:0] q_rdata;

    obb_sat_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_corner0_x (i_corner0_x),
        .i_corner0_y (i_corner0_y),
        .i_corner1_x (i_corner1_x),
        .i_corner1_y (i_corner1_y),
        .i_corner2_x (i_corner2_x),
        .i_corner2_y (i_corner2_y),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_data    (q_wdata)
    );

    obb_sat_fifo #(
        .WIDTH(QW),
        .DEPTH(obb_sat_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    obb_sat_back #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_data          (q_rdata),
        .o_q_pop           (q_pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_overlap         (o_overlap),
        .o_separating_axis (o_separating_axis)
    );

endmodule

// ===== src/obb_sat_checker.sv =====
// Port-level checks on the overlap block's result channel, bound to the top level.
// Uses obb_sat_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "obb_separating_axis_test_macros.svh"

module obb_sat_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_overlap,
    input logic [2:0] o_separating_axis
);

    // a stalled result holds until taken
    `OBB_SAT_ASSERT_NEXT(a_result_holds, o_out_valid && i_out_stall, o_out_valid && $stable(o_overlap) && $stable(o_separating_axis), "stalled result changed")

    // overlap and the no-axis code must agree
    `OBB_SAT_ASSERT_NOW(a_overlap_matches_axis, o_out_valid, o_overlap == (o_separating_axis == obb_sat_pkg::AXIS_NONE), "overlap flag disagrees with axis")

    // no code beyond the no-axis code
    `OBB_SAT_ASSERT_NOW(a_axis_range, o_out_valid, o_separating_axis <= obb_sat_pkg::AXIS_NONE, "separating axis out of range")

endmodule

bind obb_separating_axis_test obb_sat_checker u_checker (.*);

// ===== verif/tb_obb_separating_axis_test.sv =====
// Self-checking testbench for obb_separating_axis_test: directed rows, then random rectangles.
// Depends on obb_sat_pkg and the RTL under src; expected verdicts come from a local predictor or a typed row.
`timescale 1ns / 1ps

module tb_obb_separating_axis_test;

    localparam int COORD_W    = 16;
    localparam int NUM_RANDOM = 1730;
    localparam int HOLD_AT    = 200;   // result count at which the receiver holds off
    localparam int HOLD_LEN   = 60;
    localparam int DRAIN_AT   = 1000;  // random request before which the sender drains
    localparam int CMAX       = 32767;
    localparam int CMIN       = -32768;

    localparam logic [2:0] AXIS_B_EDGE01 = 3'd2;

    typedef logic [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord cx, cy, x0, y0, x1, y1, x2, y2;
    } t_rect;

    typedef struct packed {
        logic       overlap;
        logic [2:0] axis;
    } t_verdict;

    typedef struct {
        bit kind;
        int cx, cy, x0, y0, x1, y1, x2, y2;
        bit typed;
        bit ov;
        int axis;
    } t_stim_row;

    localparam int NUM_DIRECTED = 21;

    t_stim_row directed_rows [NUM_DIRECTED] = '{
        // tests against the reset rectangle A, a single point at the origin
        '{obb_sat_pkg::KIND_TEST,  0, 0, 0, 0, 0, 0, 0, 0,  1, 1, obb_sat_pkg::AXIS_NONE},
        '{obb_sat_pkg::KIND_TEST,  100, 0, 90, -10, 110, -10, 110, 10,
          1, 0, AXIS_B_EDGE01},
        '{obb_sat_pkg::KIND_TEST,  5, 5, -5, -5, 15, -5, 15, 15,
          1, 1, obb_sat_pkg::AXIS_NONE},
        // axis-aligned square A, then overlap, touch and each axis separating
        '{obb_sat_pkg::KIND_STORE, 0, 0, -10, -10, 10, -10, 10, 10,      0, 0, 0},
        '{obb_sat_pkg::KIND_TEST,  15, 0, 5, -10, 25, -10, 25, 10,       0, 0, 0},
        '{obb_sat_pkg::KIND_TEST,  20, 0, 10, -10, 30, -10, 30, 10,      0, 0, 0},
        '{obb_sat_pkg::KIND_TEST,  21, 0, 11, -10, 31, -10, 31, 10,      0, 0, 0},
        '{obb_sat_pkg::KIND_TEST,  0, 21, -10, 11, 10, 11, 10, 31,       0, 0, 0},
        '{obb_sat_pkg::KIND_TEST,  14, 14, 8, 14, 14, 8, 20, 14,         0, 0, 0},
        '{obb_sat_pkg::KIND_TEST,  14, 14, 14, 8, 20, 14, 14, 20,        0, 0, 0},
        // zero-length B edge
        '{obb_sat_pkg::KIND_TEST,  1000, 1000, 1000, 990, 1000, 990, 1010, 990, 0, 0, 0},
        // both rectangles collapsed to points at opposite extremes
        '{obb_sat_pkg::KIND_STORE, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 0, 0, 0},
        '{obb_sat_pkg::KIND_TEST,  CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
          1, 1, obb_sat_pkg::AXIS_NONE},
        // extremes of every coordinate, then a small store and test; shapes that are no rectangle
        '{obb_sat_pkg::KIND_STORE, CMIN, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX, 0, 0, 0},
        '{obb_sat_pkg::KIND_TEST,  CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, 0, 0, 0},
        '{obb_sat_pkg::KIND_TEST,  CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX, 0, 0, 0},
        '{obb_sat_pkg::KIND_STORE, 0, 0, -30, -5, 20, -10, 7, 40,        0, 0, 0},
        '{obb_sat_pkg::KIND_TEST,  10, 10, 0, 0, 25, 3, 18, 30,          0, 0, 0},
        // rotated square A, identical B, then a far B
        '{obb_sat_pkg::KIND_STORE, 100, 100, 100, 80, 120, 100, 100, 120, 0, 0, 0},
        '{obb_sat_pkg::KIND_TEST,  100, 100, 100, 80, 120, 100, 100, 120, 0, 0, 0},
        '{obb_sat_pkg::KIND_TEST,  -3000, 2500, -3010, 2490, -2990, 2490, -2990, 2510,
          0, 0, 0}
    };

    logic   i_clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   in_kind = 1'b0;
    t_rect  in_rect = '0;
    logic   out_stall = 1'b0;
    logic   o_in_stall;
    logic   o_out_valid;
    logic   o_overlap;
    logic [2:0] o_separating_axis;

    t_rect    rect_a = '0;
    t_verdict pending_verdicts [$];
    int       mismatches = 0;
    int       requests_sent = 0;
    int       sender_idle_max = 3;

    obb_separating_axis_test #(
        .COORD_WIDTH(COORD_W)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (in_kind),
        .i_center_x       (in_rect.cx),
        .i_center_y       (in_rect.cy),
        .i_corner0_x      (in_rect.x0),
        .i_corner0_y      (in_rect.y0),
        .i_corner1_x      (in_rect.x1),
        .i_corner1_y      (in_rect.y1),
        .i_corner2_x      (in_rect.x2),
        .i_corner2_y      (in_rect.y2),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_overlap        (o_overlap),
        .o_separating_axis(o_separating_axis)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic longint wide(t_coord v);
        return longint'($signed(v));
    endfunction

    function automatic longint abs_dot(longint px, longint py, longint ax, longint ay);
        longint v;
        v = px * ax + py * ay;
        return (v < 0) ? -v : v;
    endfunction

    // Larger projection of corner 0 and corner 1 about the center.
    function automatic longint half_span(t_rect r, longint ax, longint ay);
        longint p0, p1;
        p0 = abs_dot(wide(r.x0) - wide(r.cx), wide(r.y0) - wide(r.cy), ax, ay);
        p1 = abs_dot(wide(r.x1) - wide(r.cx), wide(r.y1) - wide(r.cy), ax, ay);
        return (p1 > p0) ? p1 : p0;
    endfunction

    function automatic t_verdict predict_verdict(t_rect a, t_rect b);
        longint   ax [obb_sat_pkg::NUM_AXES];
        longint   ay [obb_sat_pkg::NUM_AXES];
        t_verdict v;
        int       i;
        ax[0] = wide(a.x1) - wide(a.x0);
        ay[0] = wide(a.y1) - wide(a.y0);
        ax[1] = wide(a.x2) - wide(a.x1);
        ay[1] = wide(a.y2) - wide(a.y1);
        ax[2] = wide(b.x1) - wide(b.x0);
        ay[2] = wide(b.y1) - wide(b.y0);
        ax[3] = wide(b.x2) - wide(b.x1);
        ay[3] = wide(b.y2) - wide(b.y1);
        v.overlap = 1'b1;
        v.axis    = obb_sat_pkg::AXIS_NONE;
        for (i = 0; i < obb_sat_pkg::NUM_AXES; i++) begin
            if (abs_dot(wide(a.cx) - wide(b.cx), wide(a.cy) - wide(b.cy), ax[i], ay[i]) >
                half_span(a, ax[i], ay[i]) + half_span(b, ax[i], ay[i])) begin
                v.overlap = 1'b0;
                v.axis    = 3'(i);
                break;
            end
        end
        return v;
    endfunction

    function automatic int spread(int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    // Well-formed rectangle near (ocx, ocy); edges (ux, uy)*2s and (-uy, ux)*2t.
    function automatic t_rect make_rect(int ocx, int ocy, int reach);
        int    cx, cy, ux, uy, s, t, sz;
        t_rect r;
        cx = ocx + spread(reach);
        cy = ocy + spread(reach);
        ux = spread(8);
        uy = spread(8);
        sz = 4 << (2 * $urandom_range(0, 3));
        s  = $urandom_range(0, sz);
        t  = $urandom_range(0, sz);
        r.cx = t_coord'(cx);
        r.cy = t_coord'(cy);
        r.x0 = t_coord'(cx - ux * s + uy * t);
        r.y0 = t_coord'(cy - uy * s - ux * t);
        r.x1 = t_coord'(cx + ux * s + uy * t);
        r.y1 = t_coord'(cy + uy * s - ux * t);
        r.x2 = t_coord'(cx + ux * s - uy * t);
        r.y2 = t_coord'(cy + uy * s + ux * t);
        return r;
    endfunction

    function automatic t_rect noise_rect();
        t_rect r;
        r.cx = t_coord'($urandom);
        r.cy = t_coord'($urandom);
        r.x0 = t_coord'($urandom);
        r.y0 = t_coord'($urandom);
        r.x1 = t_coord'($urandom);
        r.y1 = t_coord'($urandom);
        r.x2 = t_coord'($urandom);
        r.y2 = t_coord'($urandom);
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
        end
    endtask

    // Offer one request and wait for it to be taken; update the predictor on acceptance.
    task automatic offer_request(input bit kind, input t_rect r, input bit typed,
                                 input t_verdict typed_v, input bit drain);
        int gap;
        if (requests_sent % 50 == 0) begin
            sender_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
        end
        gap = $urandom_range(0, sender_idle_max);
        if (drain && gap == 0) begin
            gap = 1;
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            while (drain && pending_verdicts.size() != 0) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_kind  <= kind;
        in_rect  <= r;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        requests_sent++;
        if (kind == obb_sat_pkg::KIND_STORE) begin
            rect_a = r;
        end else begin
            pending_verdicts.push_back(typed ? typed_v : predict_verdict(rect_a, r));
        end
    endtask

    initial begin : result_side
        int       gap;
        int       seen;
        int       idle_max;
        t_verdict want;
        seen     = 0;
        idle_max = 3;
        while (!rst_n) @(posedge i_clk);
        forever begin
            if (seen % 50 == 0) begin
                idle_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
            end
            // hold off once for long enough that the queue fills and the input stalls
            gap = (seen == HOLD_AT) ? HOLD_LEN : $urandom_range(0, idle_max);
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            do begin
                @(posedge i_clk);
            end while (!o_out_valid);
            seen++;
            if (pending_verdicts.size() == 0) begin
                flag_mismatch("result with no test pending, overlap", -1, int'(o_overlap));
            end else begin
                want = pending_verdicts.pop_front();
                if (o_overlap !== want.overlap) begin
                    flag_mismatch("overlap", int'(want.overlap), int'(o_overlap));
                end
                if (o_separating_axis !== want.axis) begin
                    flag_mismatch("separating axis", int'(want.axis),
                                  int'(o_separating_axis));
                end
            end
        end
    end

    initial begin : request_side
        t_stim_row row;
        t_rect     r;
        t_verdict  v;
        int        pick;
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            r.cx = t_coord'(row.cx);
            r.cy = t_coord'(row.cy);
            r.x0 = t_coord'(row.x0);
            r.y0 = t_coord'(row.y0);
            r.x1 = t_coord'(row.x1);
            r.y1 = t_coord'(row.y1);
            r.x2 = t_coord'(row.x2);
            r.y2 = t_coord'(row.y2);
            v.overlap = row.ov;
            v.axis    = row.axis[2:0];
            offer_request(row.kind, r, row.typed, v, 1'b0);
        end

        v = '0;
        for (int n = 0; n < NUM_RANDOM; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 18) begin
                offer_request(obb_sat_pkg::KIND_STORE, make_rect(0, 0, 12000), 1'b0, v,
                              n == DRAIN_AT);
            end else if (pick < 23) begin
                offer_request(obb_sat_pkg::KIND_STORE, noise_rect(), 1'b0, v, n == DRAIN_AT);
            end else if (pick < 92) begin
                r = make_rect(int'(wide(rect_a.cx)), int'(wide(rect_a.cy)),
                              16 << (2 * $urandom_range(0, 3)));
                offer_request(obb_sat_pkg::KIND_TEST, r, 1'b0, v, n == DRAIN_AT);
            end else begin
                offer_request(obb_sat_pkg::KIND_TEST, noise_rect(), 1'b0, v, n == DRAIN_AT);
            end
        end
        in_valid <= 1'b0;

        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/obb_sat_pkg.sv
src/obb_sat_fifo.sv
src/obb_sat_front.sv
src/obb_sat_back.sv
src/obb_separating_axis_test.sv
src/obb_sat_checker.sv
verif/tb_obb_separating_axis_test.sv
